[design/scld_pkg.sv]
// Shared types and constants for the serial command line decoder.
// No dependencies; every other design file but scld_if refers to this package by scoped names.
package scld_pkg;

   localparam int LINE_CHARS_DEF = 31;
   localparam int Q_DEPTH        = 2;
   localparam int Q_PTR_W        = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W        = $clog2(Q_DEPTH + 1);

   localparam logic [7:0] THRESH_RESET = 8'd80;
   localparam logic [7:0] THRESH_MAX   = 8'd255;
   localparam logic [4:0] ENABLE_MASK  = 5'h1F;
   localparam int         ENABLE_BITS  = 5;

   // command codes
   localparam logic [2:0] CMD_ENABLE  = 3'd0;
   localparam logic [2:0] CMD_SRC0    = 3'd1;
   localparam logic [2:0] CMD_SRC1    = 3'd2;
   localparam logic [2:0] CMD_THRESH  = 3'd3;
   localparam logic [2:0] CMD_FILL    = 3'd4;
   localparam logic [2:0] CMD_STATUS  = 3'd5;
   localparam logic [2:0] CMD_UNKNOWN = 3'd6;

   // characters
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_A     = 8'h41;
   localparam logic [7:0] CH_C     = 8'h43;
   localparam logic [7:0] CH_F     = 8'h46;
   localparam logic [7:0] CH_H     = 8'h48;
   localparam logic [7:0] CH_I     = 8'h49;
   localparam logic [7:0] CH_L     = 8'h4C;
   localparam logic [7:0] CH_R     = 8'h52;
   localparam logic [7:0] CH_S     = 8'h53;
   localparam logic [7:0] CH_T     = 8'h54;

   // one classified received character
   typedef struct packed {
      logic [7:0] ch;
      logic       is_term;
      logic       is_zero;
      logic       is_space;
      logic       is_bit;
      logic       is_ws;
      logic       is_digit;
      logic       is_sign;
      logic       is_minus;
   } word_type;

   // queue handshake between the front and the back
   typedef struct packed {
      logic     valid;
      word_type word;
   } push_type;

endpackage

[design/scld_if.sv]
// Channel interfaces for the serial command line decoder.
// Depends on scld_pkg for nothing but sits after it in compile order.
interface scld_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface scld_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  command;
   logic [4:0]  enable_mask;
   logic [7:0]  threshold;
   logic        source_select;
   logic [16:0] control_word;

   modport source (output valid, output command, output enable_mask, output threshold,
                   output source_select, output control_word, input ready);
   modport sink (input valid, input command, input enable_mask, input threshold,
                 input source_select, input control_word, output ready);
endinterface

[design/serial_command_line_decoder_unit.sv]
// Top level of the serial command line decoder: front, word queue and back end.
// Depends on scld_pkg, scld_if, scld_front, scld_queue and scld_back.
//
// Received characters enter on req_ch and are classified by the front end, queued in a
// two-word queue, and parsed one word per clock by the back end as they arrive, so no
// line buffer is walked at the terminator, and a byte is accepted every clock while the
// queue has room. A CR or LF that ends
// a non-empty line produces one word on rsp_ch with the command code and the updated
// enable mask, threshold, source select and packed control word; it waits in the queue
// only while the previous response word is still held. Empty lines produce nothing.
// Characters past LINE_CHARS in one line are dropped.
module serial_command_line_decoder_unit #(
   parameter int LINE_CHARS = scld_pkg::LINE_CHARS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   scld_req_if.sink    req_ch,
   scld_rsp_if.source  rsp_ch
);

   scld_pkg::push_type push;
   scld_pkg::word_type q_word;
   logic               q_full, q_valid, pop;

   scld_front u_front (
      .req    (req_ch),
      .q_full (q_full),
      .push   (push)
   );

   scld_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .pop     (pop),
      .q_full  (q_full),
      .q_valid (q_valid),
      .q_word  (q_word)
   );

   scld_back #(
      .LINE_CHARS (LINE_CHARS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_word  (q_word),
      .pop     (pop),
      .rsp     (rsp_ch)
   );

`ifndef ASSERT_OFF
   a_cmd_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.command <= scld_pkg::CMD_UNKNOWN))
      else $error("command code out of range");

   a_cw_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> ((rsp_ch.control_word[4:0] == rsp_ch.enable_mask) &&
                        (rsp_ch.control_word[15:8] == rsp_ch.threshold) &&
                        (rsp_ch.control_word[16] == rsp_ch.source_select)))
      else $error("control word disagrees with its fields");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid)
      else $error("queue popped while empty");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !push.valid)
      else $error("front pushed into a full queue");
`endif

endmodule

[design/scld_front.sv]
// Front end: accepts received characters and classifies them for the back end.
// Depends on scld_pkg and scld_req_if.
module scld_front (
   scld_req_if.sink             req,
   input  logic                 q_full,
   output scld_pkg::push_type   push
);

   logic [7:0] ch;

   assign ch        = req.rx_byte;
   assign req.ready = !q_full;

   always_comb begin
      push.valid         = req.valid && !q_full;
      push.word.ch       = ch;
      push.word.is_term  = (ch == scld_pkg::CH_CR) || (ch == scld_pkg::CH_LF);
      push.word.is_zero  = (ch == scld_pkg::CH_NUL);
      push.word.is_space = (ch == scld_pkg::CH_SPACE);
      push.word.is_bit   = (ch == scld_pkg::CH_ZERO) || (ch == scld_pkg::CH_ONE);
      push.word.is_ws    = (ch == scld_pkg::CH_SPACE) ||
                           ((ch >= scld_pkg::CH_TAB) && (ch <= scld_pkg::CH_CR));
      push.word.is_digit = (ch >= scld_pkg::CH_ZERO) && (ch <= scld_pkg::CH_NINE);
      push.word.is_sign  = (ch == scld_pkg::CH_PLUS) || (ch == scld_pkg::CH_MINUS);
      push.word.is_minus = (ch == scld_pkg::CH_MINUS);
   end

endmodule

[design/scld_queue.sv]
// Short word queue between the front and the back end.
// Depends on scld_pkg.
module scld_queue (
   input  logic                clock,
   input  logic                reset,
   input  scld_pkg::push_type  push,
   input  logic                pop,
   output logic                q_full,
   output logic                q_valid,
   output scld_pkg::word_type  q_word
);

   scld_pkg::word_type                  slot_ff [scld_pkg::Q_DEPTH];
   logic [scld_pkg::Q_PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [scld_pkg::Q_PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [scld_pkg::Q_CNT_W-1:0]        count_ff, count_in;
   logic                                do_push, do_pop;

   assign q_full  = (count_ff == scld_pkg::Q_CNT_W'(scld_pkg::Q_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_word  = slot_ff[rd_ptr_ff];
   assign do_push = push.valid && !q_full;
   assign do_pop  = pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == scld_pkg::Q_PTR_W'(scld_pkg::Q_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == scld_pkg::Q_PTR_W'(scld_pkg::Q_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.word;
      end
   end

endmodule

[design/scld_back.sv]
// Back end: parses the line word by word and decodes it at the line terminator.
// Depends on scld_pkg and scld_rsp_if.
module scld_back #(
   parameter int LINE_CHARS = scld_pkg::LINE_CHARS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  scld_pkg::word_type  q_word,
   output logic                pop,
   scld_rsp_if.source          rsp
);

   localparam int LW = $clog2(LINE_CHARS + 1);

   // threshold parse phases
   localparam logic [1:0] PH_WS   = 2'd0;
   localparam logic [1:0] PH_DIG  = 2'd1;
   localparam logic [1:0] PH_STOP = 2'd2;

   logic [LW-1:0] len_ff, len_in;
   logic          ended_ff, ended_in;
   logic [2:0]    tl_ff, tl_in;
   logic [7:0]    head_ff [4];
   logic          head_we;
   logic          bs_fail_ff, bs_fail_in;
   logic          bs_done_ff, bs_done_in;
   logic [2:0]    bs_n_ff, bs_n_in;
   logic [4:0]    bs_mask_ff, bs_mask_in;
   logic [1:0]    th_ph_ff, th_ph_in;
   logic          th_neg_ff, th_neg_in;
   logic [8:0]    th_val_ff, th_val_in;
   logic [4:0]    enable_ff, enable_in;
   logic [7:0]    thresh_ff, thresh_in;
   logic          src_ff, src_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    cmd_ff, cmd_in;

   logic          in_line, text_ch, emit, bs_ok, th_ok;
   logic          w_src0, w_src1, w_fill, w_stat;
   logic [11:0]   th_acc;
   logic [7:0]    th_result;

   assign in_line = (len_ff < LW'(LINE_CHARS));
   assign text_ch = in_line && !ended_ff && !q_word.is_zero;
   assign emit    = q_word.is_term && (len_ff != '0);
   assign pop     = q_valid && (!emit || !rsp_valid_ff || rsp.ready);
   assign head_we = q_valid && pop && !q_word.is_term && text_ch && (tl_ff < 3'd4);

   assign th_acc    = 12'(th_val_ff) * 12'd10 + 12'(q_word.ch[3:0]);
   assign th_result = th_neg_ff ? 8'd0 : (th_val_ff[8] ? scld_pkg::THRESH_MAX : th_val_ff[7:0]);

   assign bs_ok  = !bs_fail_ff && (bs_n_ff != 3'd0);
   assign w_src0 = (tl_ff == 3'd4) && (head_ff[0] == scld_pkg::CH_S) &&
                   (head_ff[1] == scld_pkg::CH_R) && (head_ff[2] == scld_pkg::CH_C) &&
                   (head_ff[3] == scld_pkg::CH_ZERO);
   assign w_src1 = (tl_ff == 3'd4) && (head_ff[0] == scld_pkg::CH_S) &&
                   (head_ff[1] == scld_pkg::CH_R) && (head_ff[2] == scld_pkg::CH_C) &&
                   (head_ff[3] == scld_pkg::CH_ONE);
   assign w_fill = (tl_ff == 3'd4) && (head_ff[0] == scld_pkg::CH_F) &&
                   (head_ff[1] == scld_pkg::CH_I) && (head_ff[2] == scld_pkg::CH_L) &&
                   (head_ff[3] == scld_pkg::CH_L);
   assign w_stat = (tl_ff == 3'd4) && (head_ff[0] == scld_pkg::CH_S) &&
                   (head_ff[1] == scld_pkg::CH_T) && (head_ff[2] == scld_pkg::CH_A) &&
                   (head_ff[3] == scld_pkg::CH_T);
   assign th_ok  = (tl_ff >= 3'd2) && (head_ff[0] == scld_pkg::CH_T) &&
                   (head_ff[1] == scld_pkg::CH_H) && (len_ff > LW'(2));

   always_comb begin
      len_in       = len_ff;
      ended_in     = ended_ff;
      tl_in        = tl_ff;
      bs_fail_in   = bs_fail_ff;
      bs_done_in   = bs_done_ff;
      bs_n_in      = bs_n_ff;
      bs_mask_in   = bs_mask_ff;
      th_ph_in     = th_ph_ff;
      th_neg_in    = th_neg_ff;
      th_val_in    = th_val_ff;
      enable_in    = enable_ff;
      thresh_in    = thresh_ff;
      src_in       = src_ff;
      cmd_in       = cmd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;

      if (q_valid && pop) begin
         if (!q_word.is_term) begin
            if (in_line) begin
               len_in = len_ff + 1'b1;
               if (!ended_ff && q_word.is_zero) begin
                  ended_in = 1'b1;
               end
            end
            if (text_ch) begin
               if (tl_ff < 3'd4) begin
                  tl_in = tl_ff + 1'b1;
               end
               // enable bit string
               if (!bs_fail_ff && !bs_done_ff) begin
                  if (q_word.is_space) begin
                     bs_done_in = 1'b1;
                  end else if (!q_word.is_bit || (bs_n_ff >= 3'd5)) begin
                     bs_fail_in = 1'b1;
                  end else begin
                     bs_mask_in[bs_n_ff] = q_word.ch[0];
                     bs_n_in = bs_n_ff + 1'b1;
                  end
               end
               // threshold text from the third character on
               if (len_ff >= LW'(2)) begin
                  case (th_ph_ff)
                     PH_WS: begin
                        if (q_word.is_ws) begin
                           th_ph_in = PH_WS;
                        end else if (q_word.is_sign) begin
                           th_neg_in = q_word.is_minus;
                           th_ph_in  = PH_DIG;
                        end else if (q_word.is_digit) begin
                           th_val_in = {5'd0, q_word.ch[3:0]};
                           th_ph_in  = PH_DIG;
                        end else begin
                           th_ph_in = PH_STOP;
                        end
                     end
                     PH_DIG: begin
                        if (q_word.is_digit) begin
                           th_val_in = (th_acc > 12'd255) ? 9'd256 : th_acc[8:0];
                        end else begin
                           th_ph_in = PH_STOP;
                        end
                     end
                     default: th_ph_in = PH_STOP;
                  endcase
               end
            end
         end else if (emit) begin
            rsp_valid_in = 1'b1;
            if (bs_ok) begin
               enable_in = bs_mask_ff & scld_pkg::ENABLE_MASK;
               cmd_in    = scld_pkg::CMD_ENABLE;
            end else if (w_src0) begin
               src_in = 1'b0;
               cmd_in = scld_pkg::CMD_SRC0;
            end else if (w_src1) begin
               src_in = 1'b1;
               cmd_in = scld_pkg::CMD_SRC1;
            end else if (th_ok) begin
               thresh_in = th_result;
               cmd_in    = scld_pkg::CMD_THRESH;
            end else if (w_fill) begin
               src_in = 1'b1;
               cmd_in = scld_pkg::CMD_FILL;
            end else if (w_stat) begin
               cmd_in = scld_pkg::CMD_STATUS;
            end else begin
               cmd_in = scld_pkg::CMD_UNKNOWN;
            end
            len_in     = '0;
            ended_in   = 1'b0;
            tl_in      = 3'd0;
            bs_fail_in = 1'b0;
            bs_done_in = 1'b0;
            bs_n_in    = 3'd0;
            bs_mask_in = 5'd0;
            th_ph_in   = PH_WS;
            th_neg_in  = 1'b0;
            th_val_in  = 9'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         ended_ff     <= 1'b0;
         tl_ff        <= 3'd0;
         bs_fail_ff   <= 1'b0;
         bs_done_ff   <= 1'b0;
         bs_n_ff      <= 3'd0;
         bs_mask_ff   <= 5'd0;
         th_ph_ff     <= PH_WS;
         th_neg_ff    <= 1'b0;
         th_val_ff    <= 9'd0;
         enable_ff    <= 5'd0;
         thresh_ff    <= scld_pkg::THRESH_RESET;
         src_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         ended_ff     <= ended_in;
         tl_ff        <= tl_in;
         bs_fail_ff   <= bs_fail_in;
         bs_done_ff   <= bs_done_in;
         bs_n_ff      <= bs_n_in;
         bs_mask_ff   <= bs_mask_in;
         th_ph_ff     <= th_ph_in;
         th_neg_ff    <= th_neg_in;
         th_val_ff    <= th_val_in;
         enable_ff    <= enable_in;
         thresh_ff    <= thresh_in;
         src_ff       <= src_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (head_we) begin
         head_ff[tl_ff[1:0]] <= q_word.ch;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.command       = cmd_ff;
   assign rsp.enable_mask   = enable_ff;
   assign rsp.threshold     = thresh_ff;
   assign rsp.source_select = src_ff;
   assign rsp.control_word  = {src_ff, thresh_ff, 3'd0, enable_ff};

endmodule
